// ----- sv/srcb_pkg.sv -----
`default_nettype none

package srcb_pkg;

   // sizes
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int PTR_W            = 7;
   localparam int SPEED_W          = 32;
   localparam int STEPS_W          = 32;
   localparam int PULSE_W          = 16;
   localparam int LEN_W            = 7;

   // word modes
   localparam logic [1:0] MODE_LOAD      = 2'd0;
   localparam logic [1:0] MODE_START     = 2'd1;
   localparam logic [1:0] MODE_BATCH     = 2'd2;
   localparam logic [1:0] MODE_DECEL_REQ = 2'd3;

   // run phases
   localparam logic [1:0] PH_STOP  = 2'd0;
   localparam logic [1:0] PH_ACCEL = 2'd1;
   localparam logic [1:0] PH_HOLD  = 2'd2;
   localparam logic [1:0] PH_DECEL = 2'd3;

   // sequencer -> segment memory
   typedef struct packed {
      logic               rd_en;
      logic [PTR_W-1:0]   rd_addr;
      logic               wr_speed;
      logic               wr_steps;
      logic [PTR_W-1:0]   wr_addr;
      logic [SPEED_W-1:0] wr_speed_data;
      logic [STEPS_W-1:0] wr_steps_data;
   } mem_req_type;

   // segment memory -> sequencer, already forwarded
   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [STEPS_W-1:0] steps;
   } mem_rsp_type;

   // one result word
   typedef struct packed {
      logic               send_cmd;
      logic [SPEED_W-1:0] cmd_speed;
      logic [PULSE_W-1:0] cmd_pulses;
      logic               cmd_direction;
      logic [1:0]         phase;
   } result_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic busy;
   } seq_stat_type;

   // move a pointer from the first half of the table into the second half
   function automatic logic [PTR_W-1:0] mirror_ptr(input logic [PTR_W-1:0] ptr,
                                                   input logic [LEN_W-1:0] len);
      logic [PTR_W-1:0] res;
      res = ptr;
      if ((len > LEN_W'(1)) && (ptr < (len >> 1))) begin
         res = len - ptr - PTR_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/srcb_seg_mem.sv -----
`default_nettype none

module srcb_seg_mem #(
   parameter int MAX_SEGMENTS = srcb_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire srcb_pkg::mem_req_type mem_req,
   output srcb_pkg::mem_rsp_type      mem_rsp
);
   import srcb_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int XW = (AW > PTR_W) ? AW : PTR_W;

   logic [SPEED_W-1:0] speed_mem [MAX_SEGMENTS];
   logic [STEPS_W-1:0] steps_mem [MAX_SEGMENTS];

   logic [XW-1:0]      rd_ext;
   logic [XW-1:0]      wr_ext;
   logic [AW-1:0]      rd_idx;
   logic [AW-1:0]      wr_idx;
   logic               same_addr;

   logic [SPEED_W-1:0] speed_q_ff;
   logic [STEPS_W-1:0] steps_q_ff;
   logic [SPEED_W-1:0] fwd_speed_ff;
   logic [STEPS_W-1:0] fwd_steps_ff;
   logic               fwd_speed_sel_ff;
   logic               fwd_speed_sel_in;
   logic               fwd_steps_sel_ff;
   logic               fwd_steps_sel_in;

   // addresses arrive at pointer width; callers only write in-range entries
   assign rd_ext    = XW'(mem_req.rd_addr);
   assign wr_ext    = XW'(mem_req.wr_addr);
   assign rd_idx    = rd_ext[AW-1:0];
   assign wr_idx    = wr_ext[AW-1:0];
   assign same_addr = (mem_req.rd_addr == mem_req.wr_addr);

   // storage, one write and one read port per array
   always_ff @(posedge clock) begin
      if (mem_req.wr_speed) begin
         speed_mem[wr_idx] <= mem_req.wr_speed_data;
      end
      if (mem_req.wr_steps) begin
         steps_mem[wr_idx] <= mem_req.wr_steps_data;
      end
      if (mem_req.rd_en) begin
         speed_q_ff   <= speed_mem[rd_idx];
         steps_q_ff   <= steps_mem[rd_idx];
         fwd_speed_ff <= mem_req.wr_speed_data;
         fwd_steps_ff <= mem_req.wr_steps_data;
      end
   end

   // read during write of the same entry returns the new data
   always_comb begin
      fwd_speed_sel_in = fwd_speed_sel_ff;
      fwd_steps_sel_in = fwd_steps_sel_ff;
      if (mem_req.rd_en) begin
         fwd_speed_sel_in = mem_req.wr_speed && same_addr;
         fwd_steps_sel_in = mem_req.wr_steps && same_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_speed_sel_ff <= 1'b0;
         fwd_steps_sel_ff <= 1'b0;
      end else begin
         fwd_speed_sel_ff <= fwd_speed_sel_in;
         fwd_steps_sel_ff <= fwd_steps_sel_in;
      end
   end

   assign mem_rsp.speed = fwd_speed_sel_ff ? fwd_speed_ff : speed_q_ff;
   assign mem_rsp.steps = fwd_steps_sel_ff ? fwd_steps_ff : steps_q_ff;

endmodule

`default_nettype wire

// ----- sv/srcb_seq.sv -----
`default_nettype none

module srcb_seq #(
   parameter int MAX_SEGMENTS = srcb_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [srcb_pkg::LEN_W-1:0]    table_length,
   input  wire logic [srcb_pkg::PULSE_W-1:0]  batch_limit,
   input  wire logic                          req_accept,
   input  wire logic [1:0]                    mode,
   input  wire logic [5:0]                    entry_index,
   input  wire logic [srcb_pkg::SPEED_W-1:0]  speed_word,
   input  wire logic [srcb_pkg::STEPS_W-1:0]  segment_steps,
   input  wire logic                          direction,
   input  wire logic                          s1_go,
   output srcb_pkg::seq_stat_type             stat,
   output srcb_pkg::result_type               result,
   output srcb_pkg::mem_req_type              mem_req,
   input  wire srcb_pkg::mem_rsp_type         mem_rsp
);
   import srcb_pkg::*;

   localparam int MaxLenInt = (MAX_SEGMENTS > 127) ? 127 : MAX_SEGMENTS;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MaxLenInt);

   // execute stage, one word
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [1:0]         s1_mode_ff;
   logic [5:0]         s1_idx_ff;
   logic [SPEED_W-1:0] s1_speed_ff;
   logic [STEPS_W-1:0] s1_steps_ff;
   logic               s1_dir_ff;
   logic [PTR_W-1:0]   s1_ptr_ff;

   // run state
   logic [PTR_W-1:0]   ptr_ff;
   logic [PTR_W-1:0]   ptr_in;
   logic [1:0]         phase_ff;
   logic [1:0]         phase_in;
   logic               dir_ff;
   logic               dir_in;

   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   half;
   logic [PULSE_W-1:0] lim;
   logic               ptr_ok;
   logic               idx_ok;
   logic [SPEED_W-1:0] seg_speed;
   logic [STEPS_W-1:0] seg_steps;
   logic               over;
   logic [PULSE_W-1:0] drain_pulses;
   logic [STEPS_W-1:0] drain_rest;
   logic [PTR_W-1:0]   ptr_step;
   logic [PTR_W-1:0]   rd_ptr;

   // effective configuration
   always_comb begin
      len = table_length;
      if (table_length == '0) begin
         len = LEN_W'(1);
      end else if (table_length > MAX_LEN) begin
         len = MAX_LEN;
      end
      half = len >> 1;
      lim  = (batch_limit == '0) ? PULSE_W'(1) : batch_limit;
   end

   // segment data of the word in execute; out-of-store entries read as zero
   assign ptr_ok    = (32'(s1_ptr_ff) < 32'(MAX_SEGMENTS));
   assign idx_ok    = (32'(s1_idx_ff) < 32'(MAX_SEGMENTS));
   assign seg_speed = ptr_ok ? mem_rsp.speed : '0;
   assign seg_steps = ptr_ok ? mem_rsp.steps : '0;

   // one drain step: full batch or the rest of the segment
   assign over         = (seg_steps > STEPS_W'(lim));
   assign drain_pulses = over ? lim : seg_steps[PULSE_W-1:0];
   assign drain_rest   = over ? (seg_steps - STEPS_W'(lim)) : '0;
   assign ptr_step     = s1_ptr_ff + PTR_W'(1);

   // execute the word, then pick the read pointer for the next one
   always_comb begin
      ptr_in         = ptr_ff;
      phase_in       = phase_ff;
      dir_in         = dir_ff;
      result         = '0;
      mem_req        = '0;

      if (s1_go) begin
         case (s1_mode_ff)
            MODE_LOAD: begin
               mem_req.wr_speed      = idx_ok;
               mem_req.wr_steps      = idx_ok;
               mem_req.wr_addr       = {1'b0, s1_idx_ff};
               mem_req.wr_speed_data = s1_speed_ff;
               mem_req.wr_steps_data = s1_steps_ff;
            end
            MODE_START: begin
               ptr_in   = '0;
               phase_in = PH_ACCEL;
               dir_in   = s1_dir_ff;
            end
            MODE_DECEL_REQ: begin
               if ((phase_ff == PH_ACCEL) || (phase_ff == PH_HOLD)) begin
                  phase_in = PH_DECEL;
                  ptr_in   = mirror_ptr(ptr_ff, len);
               end
            end
            MODE_BATCH: begin
               case (phase_ff)
                  PH_ACCEL: begin
                     result.send_cmd      = 1'b1;
                     result.cmd_speed     = seg_speed;
                     result.cmd_direction = dir_ff;
                     if (len == LEN_W'(1)) begin
                        // flat profile
                        result.cmd_pulses = lim;
                        phase_in          = PH_HOLD;
                     end else begin
                        result.cmd_pulses     = drain_pulses;
                        mem_req.wr_steps      = ptr_ok;
                        mem_req.wr_addr       = s1_ptr_ff;
                        mem_req.wr_steps_data = drain_rest;
                        if (!over) begin
                           ptr_in = ptr_step;
                           if (ptr_step >= half) begin
                              ptr_in   = half - PTR_W'(1);
                              phase_in = PH_HOLD;
                           end
                        end
                     end
                  end
                  PH_HOLD: begin
                     result.send_cmd      = 1'b1;
                     result.cmd_speed     = seg_speed;
                     result.cmd_pulses    = lim;
                     result.cmd_direction = dir_ff;
                  end
                  PH_DECEL: begin
                     if (len == LEN_W'(1)) begin
                        phase_in = PH_STOP;
                     end else begin
                        // s1_ptr already holds the mirrored pointer
                        ptr_in = s1_ptr_ff;
                        if (s1_ptr_ff >= len) begin
                           phase_in = PH_STOP;
                        end else begin
                           result.send_cmd       = 1'b1;
                           result.cmd_speed      = seg_speed;
                           result.cmd_pulses     = drain_pulses;
                           result.cmd_direction  = dir_ff;
                           mem_req.wr_steps      = ptr_ok;
                           mem_req.wr_addr       = s1_ptr_ff;
                           mem_req.wr_steps_data = drain_rest;
                           if (!over) begin
                              ptr_in = ptr_step;
                           end
                        end
                     end
                  end
                  default: begin
                     // stopped: ignored
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      result.phase = phase_in;

      // next word reads from the state this word leaves
      rd_ptr = ptr_in;
      if (len == LEN_W'(1)) begin
         rd_ptr = '0;
      end else if (phase_in == PH_DECEL) begin
         rd_ptr = mirror_ptr(ptr_in, len);
      end
      mem_req.rd_en   = req_accept;
      mem_req.rd_addr = rd_ptr;
   end

   // execute stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         ptr_ff      <= '0;
         phase_ff    <= PH_STOP;
         dir_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         ptr_ff      <= ptr_in;
         phase_ff    <= phase_in;
         dir_ff      <= dir_in;
      end
   end

   // word payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= mode;
         s1_idx_ff   <= entry_index;
         s1_speed_ff <= speed_word;
         s1_steps_ff <= segment_steps;
         s1_dir_ff   <= direction;
         s1_ptr_ff   <= rd_ptr;
      end
   end

   assign stat.busy = s1_valid_ff;

endmodule

`default_nettype wire

// ----- sv/stepper_run_continuous_batcher_unit.sv -----
// Flow: a word accepted into the execute stage moves into the output register once
//   that register is empty or being taken, then waits there until taken.
// Acceptance: the execute stage takes a word only while it or the output register is empty,
//   so no new word is accepted while both hold one.
// Reset (synchronous): run stopped, pointer and direction zero, table_length and
//   batch_limit one; segment memory contents stay undefined until loaded.
`default_nettype none

module stepper_run_continuous_batcher_unit #(
   parameter int MAX_SEGMENTS = srcb_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [5:0]                   req_entry_index,
   input  wire logic [srcb_pkg::SPEED_W-1:0] req_speed_word,
   input  wire logic [srcb_pkg::STEPS_W-1:0] req_segment_steps,
   input  wire logic                         req_direction,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_send_cmd,
   output logic [srcb_pkg::SPEED_W-1:0]      rsp_cmd_speed,
   output logic [srcb_pkg::PULSE_W-1:0]      rsp_cmd_pulses,
   output logic                              rsp_cmd_direction,
   output logic [1:0]                        rsp_phase,
   input  wire logic                         csr_write_enable,
   input  wire logic                         csr_index,
   input  wire logic [srcb_pkg::PULSE_W-1:0] csr_write_data
);
   import srcb_pkg::*;

   localparam logic CSR_TABLE_LENGTH = 1'b0;
   localparam logic CSR_BATCH_LIMIT  = 1'b1;

   logic [LEN_W-1:0]   table_length_ff;
   logic [PULSE_W-1:0] batch_limit_ff;

   logic               req_accept;
   logic               s1_go;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         result;
   result_type         rsp_word_ff;
   seq_stat_type       stat;
   mem_req_type        mem_req;
   mem_rsp_type        mem_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= LEN_W'(1);
         batch_limit_ff  <= PULSE_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TABLE_LENGTH: table_length_ff <= csr_write_data[LEN_W-1:0];
            CSR_BATCH_LIMIT:  batch_limit_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // handshakes: execute stage frees when the output register can take its word
   assign req_ready  = !stat.busy || !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign s1_go      = stat.busy && (!rsp_valid_ff || rsp_ready);

   srcb_seq #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .table_length  (table_length_ff),
      .batch_limit   (batch_limit_ff),
      .req_accept    (req_accept),
      .mode          (req_mode),
      .entry_index   (req_entry_index),
      .speed_word    (req_speed_word),
      .segment_steps (req_segment_steps),
      .direction     (req_direction),
      .s1_go         (s1_go),
      .stat          (stat),
      .result        (result),
      .mem_req       (mem_req),
      .mem_rsp       (mem_rsp)
   );

   srcb_seg_mem #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_seg_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_cmd      = rsp_word_ff.send_cmd;
   assign rsp_cmd_speed     = rsp_word_ff.cmd_speed;
   assign rsp_cmd_pulses    = rsp_word_ff.cmd_pulses;
   assign rsp_cmd_direction = rsp_word_ff.cmd_direction;
   assign rsp_phase         = rsp_word_ff.phase;

   // an accepted word always lands in the execute stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stat.busy)
      else $error("accepted word not held in execute stage");

   // a finished word always reaches the output register
   a_go_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("executed word lost before output register");

   // a batch command never leaves the run stopped
   a_send_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_send_cmd) |-> (rsp_phase != PH_STOP))
      else $error("batch command issued with run stopped");

endmodule

`default_nettype wire

// ----- test/stepper_run_continuous_batcher_unit_tb.sv -----
`default_nettype none

module stepper_run_continuous_batcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srcb_pkg::*;

   // csr register indexes
   localparam logic REG_TABLE_LENGTH = 1'b0;
   localparam logic REG_BATCH_LIMIT  = 1'b1;

   localparam int STORE_DEPTH     = 64;
   localparam int RSP_HOLD_CYCLES = 400;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_mode;
   logic [5:0]          req_entry_index;
   logic [SPEED_W-1:0]  req_speed_word;
   logic [STEPS_W-1:0]  req_segment_steps;
   logic                req_direction;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_send_cmd;
   logic [SPEED_W-1:0]  rsp_cmd_speed;
   logic [PULSE_W-1:0]  rsp_cmd_pulses;
   logic                rsp_cmd_direction;
   logic [1:0]          rsp_phase;
   logic                csr_write_enable;
   logic                csr_index;
   logic [PULSE_W-1:0]  csr_write_data;

   stepper_run_continuous_batcher_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_entry_index   (req_entry_index),
      .req_speed_word    (req_speed_word),
      .req_segment_steps (req_segment_steps),
      .req_direction     (req_direction),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_cmd      (rsp_send_cmd),
      .rsp_cmd_speed     (rsp_cmd_speed),
      .rsp_cmd_pulses    (rsp_cmd_pulses),
      .rsp_cmd_direction (rsp_cmd_direction),
      .rsp_phase         (rsp_phase),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // sequencer shadow state
   logic [SPEED_W-1:0] shadow_speed [STORE_DEPTH];
   logic [STEPS_W-1:0] shadow_left  [STORE_DEPTH];
   logic [PTR_W-1:0]   shadow_ptr;
   logic [1:0]         shadow_phase;
   logic               shadow_dir;
   logic [LEN_W-1:0]   shadow_len_reg;
   logic [PULSE_W-1:0] shadow_limit_reg;

   result_type batch_cmds_due[$];
   int         err_count;
   int         words_counted;
   bit         idling_on;
   bit         rsp_stall_long;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int active_len();
      if (shadow_len_reg == '0) return 1;
      if (int'(shadow_len_reg) > STORE_DEPTH) return STORE_DEPTH;
      return int'(shadow_len_reg);
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_cap();
      return (shadow_limit_reg == '0) ? PULSE_W'(1) : shadow_limit_reg;
   endfunction

   function automatic logic [SPEED_W-1:0] stored_speed(input int i);
      return (i < STORE_DEPTH) ? shadow_speed[i] : '0;
   endfunction

   // step counts mostly a few batches long, sometimes anything
   function automatic logic [STEPS_W-1:0] rand_steps();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, 3 * int'(pulse_cap()));
   endfunction

   // first half pointer -> its mirror in the second half
   task automatic fold_pointer(input int len);
      if (len > 1 && int'(shadow_ptr) < len / 2)
         shadow_ptr = PTR_W'(len - int'(shadow_ptr) - 1);
   endtask

   // one batch from the current segment; done when the segment is empty
   task automatic drain_segment(inout result_type cmd, output bit done);
      int                 p;
      logic [STEPS_W-1:0] left;
      logic [PULSE_W-1:0] cap;
      p = int'(shadow_ptr);
      cap = pulse_cap();
      left = (p < STORE_DEPTH) ? shadow_left[p] : '0;
      cmd.send_cmd = 1'b1;
      cmd.cmd_speed = stored_speed(p);
      cmd.cmd_direction = shadow_dir;
      if (left > STEPS_W'(cap)) begin
         cmd.cmd_pulses = cap;
         if (p < STORE_DEPTH) shadow_left[p] = left - STEPS_W'(cap);
         done = 1'b0;
      end else begin
         cmd.cmd_pulses = left[PULSE_W-1:0];
         if (p < STORE_DEPTH) shadow_left[p] = '0;
         shadow_ptr = shadow_ptr + PTR_W'(1);
         done = 1'b1;
      end
   endtask

   // advance the shadow for one accepted word and queue its result
   task automatic predict_batch_cmd(input logic [1:0] mode, input logic [5:0] idx,
                                    input logic [SPEED_W-1:0] spd,
                                    input logic [STEPS_W-1:0] stp, input logic dir,
                                    output bit ignored);
      result_type cmd;
      int         len;
      bit         done;
      cmd = '0;
      len = active_len();
      ignored = 1'b0;
      case (mode)
         MODE_LOAD: begin
            shadow_speed[idx] = spd;
            shadow_left[idx] = stp;
         end
         MODE_START: begin
            shadow_ptr = '0;
            shadow_phase = PH_ACCEL;
            shadow_dir = dir;
         end
         MODE_DECEL_REQ: begin
            if (shadow_phase == PH_ACCEL || shadow_phase == PH_HOLD) begin
               shadow_phase = PH_DECEL;
               fold_pointer(len);
            end else begin
               ignored = 1'b1;
            end
         end
         default: begin
            case (shadow_phase)
               PH_ACCEL: begin
                  if (len == 1) begin
                     cmd.send_cmd = 1'b1;
                     cmd.cmd_speed = stored_speed(0);
                     cmd.cmd_pulses = pulse_cap();
                     cmd.cmd_direction = shadow_dir;
                     shadow_phase = PH_HOLD;
                  end else begin
                     drain_segment(cmd, done);
                     // ramp done: park on the last accel segment
                     if (done && int'(shadow_ptr) >= len / 2) begin
                        shadow_ptr = PTR_W'(len / 2 - 1);
                        shadow_phase = PH_HOLD;
                     end
                  end
               end
               PH_HOLD: begin
                  cmd.send_cmd = 1'b1;
                  cmd.cmd_speed = stored_speed((len == 1) ? 0 : int'(shadow_ptr));
                  cmd.cmd_pulses = pulse_cap();
                  cmd.cmd_direction = shadow_dir;
               end
               PH_DECEL: begin
                  if (len == 1) begin
                     shadow_phase = PH_STOP;
                  end else begin
                     fold_pointer(len);
                     if (int'(shadow_ptr) >= len) shadow_phase = PH_STOP;
                     else drain_segment(cmd, done);
                  end
               end
               default: ignored = 1'b1;
            endcase
         end
      endcase
      cmd.phase = shadow_phase;
      batch_cmds_due.push_back(cmd);
   endtask

   // offer one word, hold it until taken, then predict
   task automatic send_word(input logic [1:0] mode, input logic [5:0] idx,
                            input logic [SPEED_W-1:0] spd, input logic [STEPS_W-1:0] stp,
                            input logic dir);
      bit ignored;
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry_index <= idx;
      req_speed_word <= spd;
      req_segment_steps <= stp;
      req_direction <= dir;
      do @(posedge clock); while (!req_ready);
      predict_batch_cmd(mode, idx, spd, stp, dir, ignored);
      if (!ignored) words_counted++;
   endtask

   task automatic load_word(input logic [5:0] idx, input logic [SPEED_W-1:0] spd,
                            input logic [STEPS_W-1:0] stp);
      send_word(MODE_LOAD, idx, spd, stp, 1'($urandom));
   endtask

   task automatic start_word(input logic dir);
      send_word(MODE_START, 6'($urandom), $urandom, $urandom, dir);
   endtask

   task automatic batch_word();
      send_word(MODE_BATCH, 6'($urandom), $urandom, $urandom, 1'($urandom));
   endtask

   task automatic decel_word();
      send_word(MODE_DECEL_REQ, 6'($urandom), $urandom, $urandom, 1'($urandom));
   endtask

   // sender pause: drop valid, wait for every queued result
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (batch_cmds_due.size() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic [PULSE_W-1:0] value);
      csr_index <= idx;
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      if (idx == REG_TABLE_LENGTH) shadow_len_reg = value[LEN_W-1:0];
      else shadow_limit_reg = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_profile(input int len, input int limit);
      wait_drained();
      write_csr(REG_TABLE_LENGTH, PULSE_W'(len));
      write_csr(REG_BATCH_LIMIT, PULSE_W'(limit));
   endtask

   // one-segment table: flat run, ignored words while stopped / decelerating
   task automatic test_flat_profile();
      load_word(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      batch_word();
      decel_word();
      start_word(1'b1);
      batch_word();
      batch_word();
      decel_word();
      decel_word();
      batch_word();
   endtask

   // four segments: empty segment, restart mid-ramp, decel from accel, end of table
   task automatic test_ramp_profile();
      set_profile(4, 5);
      load_word(6'd0, 32'h0, 32'h0);
      load_word(6'd1, $urandom, 32'd12);
      load_word(6'd2, $urandom, 32'd7);
      load_word(6'd3, $urandom, 32'd3);
      start_word(1'b0);
      batch_word();
      batch_word();
      start_word(1'b1);
      batch_word();
      batch_word();
      decel_word();
      repeat (4) batch_word();
   endtask

   // every entry gets written before random runs touch the table
   task automatic test_fill_table();
      for (int i = 0; i < STORE_DEPTH; i++) load_word(6'(i), $urandom, rand_steps());
   endtask

   // receiver holds off long while the sender keeps offering batch events
   task automatic test_result_backpressure();
      idling_on = 1'b0;
      rsp_stall_long = 1'b1;
      start_word(1'($urandom));
      repeat (24) batch_word();
      wait_drained();
      idling_on = 1'b1;
   endtask

   // one run: reload part of the ramp, start, batches with noise, usually a decel, drain
   task automatic random_run();
      int len;
      int n_events;
      int budget;
      len = active_len();
      repeat ($urandom_range(1, (len < 8) ? len : 8))
         load_word(6'($urandom_range(0, len - 1)), $urandom, rand_steps());
      start_word(1'($urandom));
      n_events = $urandom_range(1, len + 6);
      repeat (n_events) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 3) == 0)
               load_word(6'($urandom), $urandom, rand_steps());
            else
               send_word(2'($urandom_range(1, 3)), 6'($urandom), $urandom, $urandom,
                         1'($urandom));
         end else begin
            batch_word();
         end
      end
      if ($urandom_range(0, 9) < 8) decel_word();
      budget = 2 * len + 10;
      while (shadow_phase != PH_STOP && budget > 0) begin
         batch_word();
         budget--;
      end
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) batch_word();
         else decel_word();
      end
   endtask

   // sweep of table lengths and batch limits, extremes and odd values included
   task automatic test_random_runs();
      int prof_len [12] = '{2, 3, 0, 8, 64, 5, 100, 127, 6, 16, 1, 4};
      int prof_lim [12] = '{1, 4, 7, 0, 65535, 3, 2, 65535, 1, 10, 2, 6};
      int goal;
      for (int i = 0; i < 12; i++) begin
         set_profile(prof_len[i], prof_lim[i]);
         idling_on = (i != 5) && (i < 10);
         goal = words_counted + 60;
         while (words_counted < goal) random_run();
      end
   endtask

   // result side ready: random stall bursts, one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_stall_long) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_stall_long = 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
         err_count++;
      end
   endtask

   // compare each taken result word with the oldest prediction
   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (batch_cmds_due.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got phase %0d",
                     $time, rsp_phase);
            err_count++;
         end else begin
            want = batch_cmds_due.pop_front();
            check_field("send_cmd", 32'(want.send_cmd), 32'(rsp_send_cmd));
            check_field("cmd_speed", want.cmd_speed, rsp_cmd_speed);
            check_field("cmd_pulses", 32'(want.cmd_pulses), 32'(rsp_cmd_pulses));
            check_field("cmd_direction", 32'(want.cmd_direction), 32'(rsp_cmd_direction));
            check_field("phase", 32'(want.phase), 32'(rsp_phase));
         end
      end
   end

   // timeout
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // main sequence
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_LOAD;
      req_entry_index <= '0;
      req_speed_word <= '0;
      req_segment_steps <= '0;
      req_direction <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= REG_TABLE_LENGTH;
      csr_write_data <= '0;
      err_count = 0;
      words_counted = 0;
      idling_on = 1'b1;
      rsp_stall_long = 1'b0;
      shadow_ptr = '0;
      shadow_phase = PH_STOP;
      shadow_dir = 1'b0;
      shadow_len_reg = LEN_W'(1);
      shadow_limit_reg = PULSE_W'(1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_flat_profile();
      test_ramp_profile();
      test_fill_table();
      test_result_backpressure();
      test_random_runs();

      wait_drained();
      repeat (8) @(posedge clock);
      if (err_count == 0 && batch_cmds_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
